// ===== sv/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants for the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

    typedef logic [7:0] char_t;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_DIGIT     = 3'd1,
        ST_CORRECT   = 3'd2,
        ST_INCORRECT = 3'd3,
        ST_CLEARED   = 3'd4,
        ST_TOGGLED   = 3'd5,
        ST_DISABLED  = 3'd6
    } status_t;

    localparam int    NUM_COLS     = 3;
    localparam int    NUM_ROWS     = 4;
    localparam int    ENTRY_DEPTH  = 4;
    localparam char_t CLEAR_CHAR   = 8'h20;
    localparam char_t ZERO_CHAR    = 8'h30;
    localparam logic [31:0] SECRET_RESET = 32'h3131_3232;

    // digit keys, [column][row], bottom row handled separately
    localparam char_t KEY_CHARS [NUM_COLS][NUM_ROWS-1] = '{
        '{8'h31, 8'h34, 8'h37},
        '{8'h32, 8'h35, 8'h38},
        '{8'h33, 8'h36, 8'h39}
    };

endpackage

// ===== sv/kcl_if.sv =====
// ----------------------------------------------------------------------------
// kcl_if
// Valid/ready channel interfaces for the keypad code lock.
// ----------------------------------------------------------------------------
interface kcl_in_if;
    import kcl_pkg::*;
    logic        valid;
    logic        ready;
    logic        op;
    logic [11:0] key_matrix;
    char_t       serial_char_0;
    char_t       serial_char_1;
    char_t       serial_char_2;
    char_t       serial_char_3;

    modport source (output valid, op, key_matrix, serial_char_0, serial_char_1,
                    serial_char_2, serial_char_3, input ready);
    modport sink   (input valid, op, key_matrix, serial_char_0, serial_char_1,
                    serial_char_2, serial_char_3, output ready);
endinterface

interface kcl_out_if;
    import kcl_pkg::*;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    char_t      digit_char;
    logic       lock_open;
    logic       keypad_on;

    modport source (output valid, status, digit_char, lock_open, keypad_on, input ready);
    modport sink   (input valid, status, digit_char, lock_open, keypad_on, output ready);
endinterface

interface kcl_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] secret_code;

    modport source (output valid, secret_code, input ready);
    modport sink   (input valid, secret_code, output ready);
endinterface

// ===== sv/keypad_code_lock.sv =====
// Path: an accepted item passes the input register, then the result register, to result valid.
// Throughput: one item per cycle unless the result side stalls; a new item is taken while a result
// waits if the input register is empty. The rate is set by the combinational decode/compare between the registers.
// Reset (rst_n low, async): lock closed, keypad enabled, entry buffer all spaces,
// entry index zero, code "1122", both pipeline registers empty.
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad / serial code lock: decodes a scan or a 4-char serial entry per item.
// ----------------------------------------------------------------------------
module keypad_code_lock
    import kcl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    kcl_in_if.sink    in_ch,
    kcl_out_if.source out_ch,
    kcl_cfg_if.sink   cfg
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_valid_reg;
    logic        op_reg;
    logic [11:0] matrix_reg;
    char_t       ser_reg [ENTRY_DEPTH];

    // Result register
    logic        out_valid_reg;
    status_t     status_reg;
    char_t       digit_reg;

    // Lock state
    logic [31:0] secret_reg;
    char_t       buf_reg [ENTRY_DEPTH];
    char_t       buf_next [ENTRY_DEPTH];
    logic [1:0]  idx_reg, idx_next;
    logic        kp_en_reg, kp_en_next;
    logic        lock_reg, lock_next;
    status_t     status_next;
    char_t       digit_next;

    logic        advance;
    logic        in_fire;

    // item moves from input register to result register when result slot frees
    assign advance = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;
    assign in_fire = in_ch.valid && in_ch.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg     <= in_ch.op;
            matrix_reg <= in_ch.key_matrix;
            ser_reg[0] <= in_ch.serial_char_0;
            ser_reg[1] <= in_ch.serial_char_1;
            ser_reg[2] <= in_ch.serial_char_2;
            ser_reg[3] <= in_ch.serial_char_3;
        end
    end

    // ------------------------------------------------------------------
    // Per-column decode: each column gives its first pressed digit row,
    // or a press on the bottom key alone.
    // ------------------------------------------------------------------
    char_t col_pin    [NUM_COLS];
    logic  col_hit    [NUM_COLS];
    logic  col_bottom [NUM_COLS];

    always_comb
    begin
        for (int c = 0; c < NUM_COLS; c++)
        begin
            col_pin[c] = '0;
            priority if (matrix_reg[c*NUM_ROWS])
                col_pin[c] = KEY_CHARS[c][0];
            else if (matrix_reg[c*NUM_ROWS+1])
                col_pin[c] = KEY_CHARS[c][1];
            else if (matrix_reg[c*NUM_ROWS+2])
                col_pin[c] = KEY_CHARS[c][2];
            else
                col_pin[c] = '0;
            col_hit[c]    = |matrix_reg[c*NUM_ROWS +: NUM_ROWS-1];
            col_bottom[c] = !col_hit[c] && matrix_reg[c*NUM_ROWS+NUM_ROWS-1];
        end
    end

    // '*' is column 1 bottom, '0' column 2 bottom, '#' column 3 bottom
    logic  star_key, hash_key;
    char_t pin;

    always_comb
    begin
        star_key = col_bottom[0];
        hash_key = col_bottom[2];
        pin = col_pin[0];
        // later columns replace earlier digits
        priority if (col_hit[1])
            pin = col_pin[1];
        else if (col_bottom[1])
            pin = ZERO_CHAR;
        else
            pin = col_pin[0];
        if (col_hit[2])
            pin = col_pin[2];
    end

    // code compares; first char sits in bits 31:24
    logic buf_match, ser_match, ser_zeros;
    assign buf_match = {buf_reg[0], buf_reg[1], buf_reg[2], buf_reg[3]} == secret_reg;
    assign ser_match = {ser_reg[0], ser_reg[1], ser_reg[2], ser_reg[3]} == secret_reg;
    assign ser_zeros = (ser_reg[0] == ZERO_CHAR) && (ser_reg[1] == ZERO_CHAR) &&
                       (ser_reg[2] == ZERO_CHAR) && (ser_reg[3] == ZERO_CHAR);

    // ------------------------------------------------------------------
    // Next state and result for the item in the input register
    // ------------------------------------------------------------------
    always_comb
    begin
        buf_next    = buf_reg;
        idx_next    = idx_reg;
        kp_en_next  = kp_en_reg;
        lock_next   = lock_reg;
        status_next = ST_NONE;
        digit_next  = '0;

        priority if (op_reg)
        begin
            // serial entry: "0000" toggles keypad, else check without touching buffer
            if (ser_zeros)
            begin
                kp_en_next  = !kp_en_reg;
                status_next = ST_TOGGLED;
            end
            else if (ser_match)
            begin
                lock_next   = !lock_reg;
                status_next = ST_CORRECT;
            end
            else
            begin
                status_next = ST_INCORRECT;
            end
        end
        else if (!kp_en_reg)
        begin
            status_next = ST_DISABLED;
        end
        else if (star_key)
        begin
            // check then clear
            if (buf_match)
            begin
                lock_next   = !lock_reg;
                status_next = ST_CORRECT;
            end
            else
            begin
                status_next = ST_INCORRECT;
            end
            for (int i = 0; i < ENTRY_DEPTH; i++)
                buf_next[i] = CLEAR_CHAR;
            idx_next = '0;
        end
        else if (hash_key)
        begin
            for (int i = 0; i < ENTRY_DEPTH; i++)
                buf_next[i] = CLEAR_CHAR;
            idx_next    = '0;
            status_next = ST_CLEARED;
        end
        else if (pin != '0)
        begin
            buf_next[idx_reg] = pin;
            idx_next          = idx_reg + 2'd1;
            status_next       = ST_DIGIT;
            digit_next        = pin;
        end
        else
        begin
            status_next = ST_NONE;
        end
    end

    // ------------------------------------------------------------------
    // State and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            secret_reg    <= SECRET_RESET;
            idx_reg       <= '0;
            kp_en_reg     <= 1'b1;
            lock_reg      <= 1'b0;
            for (int i = 0; i < ENTRY_DEPTH; i++)
                buf_reg[i] <= CLEAR_CHAR;
        end
        else
        begin
            if (cfg.valid)
                secret_reg <= cfg.secret_code;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                buf_reg       <= buf_next;
                idx_reg       <= idx_next;
                kp_en_reg     <= kp_en_next;
                lock_reg      <= lock_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg <= status_next;
            digit_reg  <= digit_next;
        end
    end

    // lock and keypad state in the result are the state right after that item
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.status     = status_reg;
    assign out_ch.digit_char = digit_reg;
    assign out_ch.lock_open  = lock_reg;
    assign out_ch.keypad_on  = kp_en_reg;

endmodule

// ===== sv/kcl_checker.sv =====
// ----------------------------------------------------------------------------
// kcl_checker
// Port-level assertions for keypad_code_lock, bound to the top level.
// ----------------------------------------------------------------------------
module kcl_checker
    import kcl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input char_t      digit_char,
    input logic       keypad_on
);

    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(digit_char))
        else $error("result dropped or changed while stalled");

    // digit only reported with a stored digit
    a_digit_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((digit_char != 8'h00) == (status == ST_DIGIT)))
        else $error("digit_char does not agree with status");

    // a stored digit requires an enabled keypad
    a_digit_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DIGIT |-> keypad_on)
        else $error("digit stored while keypad disabled");

    // an ignored scan means keypad is off
    a_disabled_off: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DISABLED |-> !keypad_on)
        else $error("scan ignored while keypad enabled");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (out_ch.status),
    .digit_char (out_ch.digit_char),
    .keypad_on  (out_ch.keypad_on)
);

// ===== verif/keypad_code_lock_tb.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock_tb
// Self-checking bench for the keypad code lock. A short directed table covers
// the decode corner cases, then random phases run code entries, serial
// entries and keypad on/off toggles under several code settings. Every
// accepted item is run through a local model of the lock and each result
// is compared field by field, in order, with the model's prediction or a pinned row's result.
// ----------------------------------------------------------------------------
module keypad_code_lock_tb;
    import kcl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // ---- bench constants ---------------------------------------------------
    localparam logic [11:0] STAR_KEY       = 12'h008;  // col 1, row 4
    localparam logic [11:0] ZERO_KEY       = 12'h080;  // col 2, row 4
    localparam logic [11:0] HASH_KEY       = 12'h800;  // col 3, row 4
    localparam char_t       KEY_ONE        = 8'h31;    // '1', top left key
    localparam char_t       KEY_NINE       = 8'h39;
    localparam logic [31:0] SPACE_WORD     = {4{CLEAR_CHAR}};
    localparam logic [31:0] ZERO_WORD      = {4{ZERO_CHAR}};
    localparam int          RANDOM_PHASES  = 8;
    localparam int          ITEMS_PER_PHASE = 215;
    localparam int          LONG_HOLD      = 120;
    localparam int          WATCHDOG_LIMIT = 3000;

    // one input item; chars holds the first serial char in bits 31:24
    typedef struct packed {
        logic        op;
        logic [11:0] key_matrix;
        logic [31:0] chars;
    } lock_item_t;

    typedef struct packed {
        status_t status;
        char_t   digit;
        logic    lock_open;
        logic    keypad_on;
    } lock_result_t;

    // row of the directed table; pinned rows carry a hand-typed result
    typedef struct {
        lock_item_t   item;
        bit           pinned;
        lock_result_t res;
    } lock_step_t;

    // ---- clock, reset, channels ---------------------------------------------
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    kcl_in_if  in_ch ();
    kcl_out_if out_ch ();
    kcl_cfg_if cfg_ch ();

    keypad_code_lock dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg_ch)
    );

    // ---- model state (mirrors the lock) ------------------------------------
    logic [31:0] code_reg   = SECRET_RESET;
    char_t       entry_buf [ENTRY_DEPTH] = '{default: CLEAR_CHAR};
    logic [1:0]  entry_idx  = 2'd0;
    logic        kp_enabled = 1'b1;
    logic        lock_state = 1'b0;

    // ---- bench bookkeeping -------------------------------------------------
    lock_result_t pending_results [$];   // oldest expectation at the front
    lock_step_t   directed_steps [$];
    bit           drv_pinned;            // travels with the item being offered
    lock_result_t drv_pinned_res;
    int           mismatches  = 0;
    int           items_sent  = 0;
    int           quiet_cycles = 0;
    bit           tx_steady   = 1'b0;    // sender: no gaps
    bit           rx_steady   = 1'b0;    // receiver: no stalls
    bit           long_hold_req = 1'b0;  // ask the receiver for one long stall

    // ---- model ---------------------------------------------------------------
    function automatic status_t try_code(logic [31:0] word);
        if (word == code_reg)
        begin
            lock_state = !lock_state;
            return ST_CORRECT;
        end
        return ST_INCORRECT;
    endfunction

    function automatic void wipe_entry();
        int k;
        for (k = 0; k < ENTRY_DEPTH; k++)
            entry_buf[k] = CLEAR_CHAR;
        entry_idx = 2'd0;
    endfunction

    // Apply one item to the model state and return the result it produces.
    function automatic lock_result_t advance_lock(lock_item_t it);
        lock_result_t r;
        char_t        pin;
        logic [3:0]   col;
        bit           hit;
        bit           done;
        int           c;
        int           row;
        r    = '0;
        pin  = 8'h00;
        done = 1'b0;
        if (it.op)
        begin
            // serial entry: "0000" flips keypad enable, anything else is a code try
            if (it.chars == ZERO_WORD)
            begin
                kp_enabled = !kp_enabled;
                r.status   = ST_TOGGLED;
            end
            else
                r.status = try_code(it.chars);
        end
        else if (!kp_enabled)
            r.status = ST_DISABLED;
        else
        begin
            for (c = 0; c < NUM_COLS && !done; c++)
            begin
                col = it.key_matrix[4*c +: 4];
                hit = 1'b0;
                // lowest pressed row wins; a later column overrides the digit
                for (row = 0; row < NUM_ROWS - 1; row++)
                    if (!hit && col[row])
                    begin
                        pin = KEY_ONE + char_t'(3 * row + c);
                        hit = 1'b1;
                    end
                // bottom row only counts with rows 1-3 of that column released
                if (!hit && col[3])
                begin
                    if (c == 0)
                    begin
                        // star: check now, clear, ignore the rest of the matrix
                        r.status = try_code({entry_buf[0], entry_buf[1],
                                             entry_buf[2], entry_buf[3]});
                        wipe_entry();
                        done = 1'b1;
                    end
                    else if (c == 1)
                        pin = ZERO_CHAR;
                    else
                    begin
                        // hash: clear and drop any digit seen so far
                        wipe_entry();
                        r.status = ST_CLEARED;
                        done     = 1'b1;
                    end
                end
            end
            if (!done && pin != 8'h00)
            begin
                entry_buf[entry_idx] = pin;
                entry_idx            = entry_idx + 2'd1;
                r.status             = ST_DIGIT;
                r.digit              = pin;
            end
        end
        r.lock_open = lock_state;
        r.keypad_on = kp_enabled;
        return r;
    endfunction

    // ---- checking ------------------------------------------------------------
    task automatic flag_mismatch(string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Results are checked before the same edge's input is modeled; an item passes the input
    // register and then the result register, so it never meets its own result on one edge anyway.
    always @(posedge clk)
    begin : scoreboard
        lock_result_t want;
        lock_item_t   took;
        lock_result_t fresh;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch("result with no item outstanding");
                else
                begin
                    want = pending_results.pop_front();
                    check_field("status", out_ch.status, want.status);
                    check_field("digit_char", out_ch.digit_char, want.digit);
                    check_field("lock_open", out_ch.lock_open, want.lock_open);
                    check_field("keypad_on", out_ch.keypad_on, want.keypad_on);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                took  = {in_ch.op, in_ch.key_matrix, in_ch.serial_char_0,
                         in_ch.serial_char_1, in_ch.serial_char_2, in_ch.serial_char_3};
                fresh = advance_lock(took);   // model always advances
                pending_results.push_back(drv_pinned ? drv_pinned_res : fresh);
            end
        end
    end

    // watchdog: no handshake of any kind for too long ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---- result side: random back-pressure -------------------------------------
    initial
    begin : result_sink
        int stall_left;
        int roll;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                // long stall: the pipeline fills and in_ch.ready must drop
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            else if (stall_left == 0 && !rx_steady)
            begin
                roll = $urandom_range(0, 99);
                if (roll >= 97)
                    stall_left = $urandom_range(15, 40);
                else if (roll >= 75)
                    stall_left = $urandom_range(1, 4);
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // ---- item helpers ------------------------------------------------------------
    function automatic lock_item_t scan(logic [11:0] m);
        return '{op: 1'b0, key_matrix: m, chars: $urandom};
    endfunction

    // matrix is junk on serial items; the lock must ignore it
    function automatic lock_item_t serial(logic [31:0] w);
        return '{op: 1'b1, key_matrix: 12'($urandom), chars: w};
    endfunction

    function automatic int pick_gap();
        int roll;
        if (tx_steady)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] random_digit_code();
        logic [31:0] w;
        int          k;
        do
        begin
            for (k = 0; k < 4; k++)
                w[8*k +: 8] = ZERO_CHAR + char_t'($urandom_range(0, 9));
        end
        while (w == ZERO_WORD);
        return w;
    endfunction

    // Offer one item at a falling edge and hold it until taken. valid stays
    // high afterwards so back-to-back items need no extra edge.
    task automatic send_item(lock_item_t it, bit counted = 1'b1, bit pin = 1'b0,
                             lock_result_t pin_res = '0);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.op            <= it.op;
        in_ch.key_matrix    <= it.key_matrix;
        in_ch.serial_char_0 <= it.chars[31:24];
        in_ch.serial_char_1 <= it.chars[23:16];
        in_ch.serial_char_2 <= it.chars[15:8];
        in_ch.serial_char_3 <= it.chars[7:0];
        drv_pinned          <= pin;
        drv_pinned_res      <= pin_res;
        do @(posedge clk); while (!in_ch.ready);
        if (counted)
            items_sent++;
    endtask

    // stop offering and wait out every outstanding result
    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // register write; only called with the lock idle
    task automatic load_code(logic [31:0] value);
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.secret_code <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        code_reg = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic add_step(bit op, logic [11:0] m, logic [31:0] w, bit pin = 1'b0,
                            status_t st = ST_NONE, char_t d = 8'h00, bit lk = 1'b0,
                            bit kp = 1'b0);
        lock_step_t s;
        s.item   = '{op: op, key_matrix: m, chars: w};
        s.pinned = pin;
        s.res    = '{status: st, digit: d, lock_open: lk, keypad_on: kp};
        directed_steps.push_back(s);
    endtask

    // One random sequence. Most are well-formed code entries so the compare
    // and toggle paths get exercised; the rest is matrix and serial noise.
    task automatic run_sequence(logic [31:0] code);
        int          pick;
        int          n;
        int          k;
        int          cidx;
        int          sub;
        bit          keyable;
        char_t       ch;
        logic [11:0] m;
        logic [31:0] w;
        keyable = 1'b1;
        for (k = 0; k < 4; k++)
            if (code[8*k +: 8] < ZERO_CHAR || code[8*k +: 8] > KEY_NINE)
                keyable = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            // keypad entry closed by star, often after a hash to reset the index
            if ($urandom_range(0, 1))
                send_item(scan(HASH_KEY));
            if (code == SPACE_WORD && $urandom_range(0, 1))
                n = 0;   // star on an empty buffer matches an all-space code
            else if (keyable && $urandom_range(0, 9) < 7)
                n = 4;
            else
                n = $urandom_range(1, 6);
            for (k = 0; k < n; k++)
            begin
                if (keyable && n == 4 && $urandom_range(0, 9) < 8)
                    ch = code[31 - 8*k -: 8];
                else
                    ch = ZERO_CHAR + char_t'($urandom_range(0, 9));
                if (ch == ZERO_CHAR)
                begin
                    m    = ZERO_KEY;
                    cidx = 1;
                end
                else
                begin
                    cidx = (int'(ch) - int'(KEY_ONE)) % 3;
                    m    = 12'h001 << (cidx * 4 + (int'(ch) - int'(KEY_ONE)) / 3);
                end
                // extra digits in earlier columns get overridden
                if (cidx > 0 && $urandom_range(0, 3) == 0)
                    m |= 12'($urandom) & (cidx == 2 ? 12'h077 : 12'h007);
                send_item(scan(m));
            end
            // star wins over anything in columns 2 and 3
            send_item(scan(STAR_KEY | ($urandom_range(0, 1) ? 12'($urandom) & 12'hFF0
                                                            : 12'h000)));
        end
        else if (pick < 60)
        begin
            // serial code try: mostly right, some one bit off, some random
            w   = code;
            sub = $urandom_range(0, 99);
            if (sub >= 85)
                w = $urandom;
            else if (sub >= 60)
                w = code ^ (32'h1 << $urandom_range(0, 31));
            if (w == ZERO_WORD)
                w ^= 32'h1;
            send_item(serial(w));
        end
        else if (pick < 68)
        begin
            // keypad off, a few ignored scans, maybe a serial try, keypad on
            send_item(serial(ZERO_WORD));
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++)
                send_item(scan(12'($urandom)), 1'b0);
            if ($urandom_range(0, 1))
                send_item(serial(code));
            send_item(serial(ZERO_WORD));
        end
        else if (pick < 85)
            send_item(scan(12'($urandom)));
        else if (pick < 93)
        begin
            // hash with digit noise (col 1 bottom kept clear), or star with noise
            if ($urandom_range(0, 1))
                send_item(scan(HASH_KEY | (12'($urandom) & 12'h0F7)));
            else
                send_item(scan(STAR_KEY | (12'($urandom) & 12'hFF0)));
        end
        else
        begin
            // serial noise, half of it one char away from "0000"
            if ($urandom_range(0, 1))
                w = $urandom;
            else
            begin
                w  = ZERO_WORD;
                ch = char_t'($urandom);
                if (ch == ZERO_CHAR)
                    ch ^= 8'h01;
                w[8 * $urandom_range(0, 3) +: 8] = ch;
            end
            if (w == ZERO_WORD)
                w ^= 32'h1;
            send_item(serial(w));
        end
    endtask

    // ---- main sequence ----------------------------------------------------------
    initial
    begin : stimulus
        logic [31:0] code;
        int          p;
        int          base;
        bit          hold_done;
        bit          pause_done;
        in_ch.valid         = 1'b0;
        in_ch.op            = 1'b0;
        in_ch.key_matrix    = 12'h000;
        in_ch.serial_char_0 = 8'h00;
        in_ch.serial_char_1 = 8'h00;
        in_ch.serial_char_2 = 8'h00;
        in_ch.serial_char_3 = 8'h00;
        cfg_ch.valid        = 1'b0;
        cfg_ch.secret_code  = 32'h0;
        drv_pinned          = 1'b0;
        drv_pinned_res      = '0;
        hold_done           = 1'b0;
        pause_done          = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed table, code still at reset "1122". Pinned rows follow
        // straight from the reset state; the others go through the model.
        add_step(1'b0, 12'h000, 32'h0, 1'b1, ST_NONE, 8'h00, 1'b0, 1'b1);
        // all keys: each column has row 1, column 3's '3' wins, bottom row ignored
        add_step(1'b0, 12'hFFF, 32'h0, 1'b1, ST_DIGIT, 8'h33, 1'b0, 1'b1);
        // "3   " against "1122"
        add_step(1'b0, STAR_KEY, 32'h0, 1'b1, ST_INCORRECT, 8'h00, 1'b0, 1'b1);
        // hash throws away the '1' found in column 1
        add_step(1'b0, HASH_KEY | 12'h001, 32'h0, 1'b1, ST_CLEARED, 8'h00, 1'b0, 1'b1);
        add_step(1'b0, ZERO_KEY, 32'h0, 1'b1, ST_DIGIT, ZERO_CHAR, 1'b0, 1'b1);
        // star alone in column 1 acts at once, columns 2 and 3 ignored
        add_step(1'b0, 12'h888, 32'h0, 1'b1, ST_INCORRECT, 8'h00, 1'b0, 1'b1);
        // right code on the keypad opens the lock
        add_step(1'b0, 12'h001, 32'h0);
        add_step(1'b0, 12'h001, 32'h0);
        add_step(1'b0, 12'h010, 32'h0);
        add_step(1'b0, 12'h010, 32'h0);
        add_step(1'b0, STAR_KEY, 32'h0);
        // hash does not count with '3' held in the same column
        add_step(1'b0, 12'h900, 32'h0);
        // keypad off; scan ignored; serial still checks the code
        add_step(1'b1, 12'h000, ZERO_WORD);
        add_step(1'b0, 12'hFFF, 32'h0);
        add_step(1'b1, 12'h000, SECRET_RESET);
        add_step(1'b1, 12'h000, 32'hFFFF_FFFF);
        add_step(1'b1, 12'h000, 32'h0000_0000);
        add_step(1'b1, 12'hFFF, ZERO_WORD);
        // five digits wrap the entry index: buffer ends as "2112"
        add_step(1'b0, HASH_KEY, 32'h0);
        add_step(1'b0, 12'h400, 32'h0);
        add_step(1'b0, 12'h001, 32'h0);
        add_step(1'b0, 12'h001, 32'h0);
        add_step(1'b0, 12'h010, 32'h0);
        add_step(1'b0, 12'h010, 32'h0);
        add_step(1'b0, STAR_KEY, 32'h0);

        foreach (directed_steps[i])
            send_item(directed_steps[i].item, 1'b1, directed_steps[i].pinned,
                      directed_steps[i].res);

        // Random phases, each under its own code: digit codes the keypad can
        // reach, the all-zero and all-one extremes, all spaces, arbitrary, and the reset code.
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            drain_results();
            case (p)
                0, 4, 6: code = random_digit_code();
                1:       code = 32'h0000_0000;
                2:       code = 32'hFFFF_FFFF;
                3:       code = SPACE_WORD;
                5:
                begin
                    code = $urandom;
                    if (code == ZERO_WORD)
                        code ^= 32'h1;
                end
                default: code = SECRET_RESET;
            endcase
            load_code(code);

            // phase 1 runs flat out; phase 2 keeps the sender busy for the long hold
            tx_steady = (p == 1 || p == 2) || ($urandom_range(0, 3) == 0);
            rx_steady = (p == 1) || ($urandom_range(0, 3) == 0);

            base = items_sent;
            while (items_sent - base < ITEMS_PER_PHASE)
            begin
                if (p == 2 && !hold_done && items_sent - base > 60)
                begin
                    long_hold_req = 1'b1;
                    hold_done     = 1'b1;
                end
                if (p == 4 && !pause_done && items_sent - base > 100)
                begin
                    // sender goes quiet until every result is back
                    drain_results();
                    pause_done = 1'b1;
                end
                run_sequence(code);
            end
        end

        drain_results();
        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
